@@ rtl/lqt_pkg.sv @@
// Shared types and constants for the linked queue table.
`default_nettype none
package lqt_pkg;

  // Link and id width; every link, pid and queue index is one byte.
  localparam int LINK_W = 8;

  // Default sizing handed to the top level.
  localparam int NUM_PROC_DEF   = 32;
  localparam int NUM_QUEUES_DEF = 8;

  // Command codes.
  localparam logic [1:0] CMD_ENQ   = 2'd0;
  localparam logic [1:0] CMD_REM   = 2'd1;
  localparam logic [1:0] CMD_DEQ   = 2'd2;
  localparam logic [1:0] CMD_ALLOC = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ERR   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [LINK_W-1:0] pid;
    logic [LINK_W-1:0] queue_id;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [LINK_W-1:0] pid_out;
    logic [LINK_W-1:0] queue_out;
  } out_word_t;

endpackage
`default_nettype wire

@@ rtl/linked_queue_table.sv @@
// Linked queue table: doubly linked FIFO queues of pids in one shared link table.
// Sequencer path from acceptance to out_valid: an error word DEC, DONE; allocate DEC,
//   AL2, DONE; remove DEC, UNL, DONE; an empty dequeue DEC, DQ1, DONE; enqueue DEC,
//   ENQ1, ENQ2, DONE; a dequeue that takes a pid DEC, DQ1, UNL, DQ3, DONE. Reads are registered.
// One word at a time: in_ready returns with out_valid, and an unaccepted result holds
//   the sequencer in DONE until the output register is free.
// Reset (rst_n low, synchronous) clears sequencer, out_valid, queue count, written bits.
`default_nettype none
module linked_queue_table #(
  parameter int NUM_PROC   = lqt_pkg::NUM_PROC_DEF,
  parameter int NUM_QUEUES = lqt_pkg::NUM_QUEUES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire lqt_pkg::in_word_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output lqt_pkg::out_word_t     out_data
);

  localparam int LW       = lqt_pkg::LINK_W;
  localparam int TAB_SIZE = NUM_PROC + 2 * NUM_QUEUES;
  localparam int ADDR_W   = $clog2(TAB_SIZE);
  localparam int IDX_W    = $clog2(NUM_PROC);
  localparam int QA_W     = $clog2(NUM_QUEUES + 1);

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DEC  = 9'b000000010,
    S_ENQ1 = 9'b000000100,
    S_ENQ2 = 9'b000001000,
    S_DQ1  = 9'b000010000,
    S_UNL  = 9'b000100000,
    S_DQ3  = 9'b001000000,
    S_AL2  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Latched command word; pid_r later holds the dequeued pid.
  logic [1:0]    cmd_r, cmd_nxt;
  logic [LW-1:0] pid_r, pid_nxt;
  logic [LW-1:0] qid_r, qid_nxt;
  logic [LW-1:0] last_r, last_nxt;

  // Result under construction and the output register.
  logic [1:0]         status_r, status_nxt;
  logic [LW-1:0]      pidout_r, pidout_nxt;
  logic [LW-1:0]      qout_r, qout_nxt;
  lqt_pkg::out_word_t out_data_r, out_data_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [QA_W-1:0] qa_r, qa_nxt;

  // Written bits for process entries; an unwritten entry reads as a self-link.
  logic [NUM_PROC-1:0] nvalid_r, pvalid_r;

  // Link memories: next links and prev links, one write and one read each.
  logic [LW-1:0] next_mem [TAB_SIZE];
  logic [LW-1:0] prev_mem [TAB_SIZE];

  logic          n_we, p_we, n_re, p_re;
  logic [LW-1:0] n_waddr, n_wdata, p_waddr, p_wdata, n_raddr, p_raddr;
  logic [LW-1:0] n_rdata_r, p_rdata_r, n_rtag_r, p_rtag_r;
  logic          n_ovr_r, p_ovr_r;
  logic [LW-1:0] n_raw, p_raw, n_link, p_link;

  // Shared sentinel address unit.
  logic [LW-1:0] sen_idx, sen_head, sen_tail;
  logic          pid_ok, q_ok, tab_full;

  function automatic logic [LW-1:0] clamp_link(input logic [LW-1:0] v);
    return ({1'b0, v} < (LW + 1)'(TAB_SIZE)) ? v : '0;
  endfunction

  function automatic logic is_proc(input logic [LW-1:0] v);
    return {1'b0, v} < (LW + 1)'(NUM_PROC);
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Resolve read data: substitute the self-link for an unwritten process entry.
  assign n_raw  = n_ovr_r ? n_rtag_r : n_rdata_r;
  assign p_raw  = p_ovr_r ? p_rtag_r : p_rdata_r;
  assign n_link = clamp_link(n_raw);
  assign p_link = clamp_link(p_raw);

  // Head sentinel of the selected queue sits at NUM_PROC + 2*index.
  assign sen_idx  = (cmd_r == lqt_pkg::CMD_ALLOC) ? LW'(qa_r) : qid_r;
  assign sen_head = LW'((LW + 1)'(NUM_PROC) + {sen_idx, 1'b0});
  assign sen_tail = LW'({1'b0, sen_head} + (LW + 1)'(1));

  assign pid_ok   = is_proc(pid_r);
  assign q_ok     = qid_r < LW'(qa_r);
  assign tab_full = qa_r >= QA_W'(NUM_QUEUES);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    pid_nxt       = pid_r;
    qid_nxt       = qid_r;
    last_nxt      = last_r;
    status_nxt    = status_r;
    pidout_nxt    = pidout_r;
    qout_nxt      = qout_r;
    qa_nxt        = qa_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    n_we = 1'b0; n_waddr = '0; n_wdata = '0;
    p_we = 1'b0; p_waddr = '0; p_wdata = '0;
    n_re = 1'b0; n_raddr = '0;
    p_re = 1'b0; p_raddr = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data.cmd;
          pid_nxt   = in_data.pid;
          qid_nxt   = in_data.queue_id;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        status_nxt = lqt_pkg::ST_OK;
        pidout_nxt = '0;
        qout_nxt   = '0;
        case (cmd_r)
          lqt_pkg::CMD_ENQ: begin
            if (!pid_ok || !q_ok) begin
              status_nxt = lqt_pkg::ST_ERR;
              state_nxt  = S_DONE;
            end else begin
              p_re      = 1'b1;
              p_raddr   = sen_tail;
              state_nxt = S_ENQ1;
            end
          end
          lqt_pkg::CMD_REM: begin
            if (!pid_ok) begin
              status_nxt = lqt_pkg::ST_ERR;
              state_nxt  = S_DONE;
            end else begin
              n_re       = 1'b1;
              n_raddr    = pid_r;
              p_re       = 1'b1;
              p_raddr    = pid_r;
              pidout_nxt = pid_r;
              state_nxt  = S_UNL;
            end
          end
          lqt_pkg::CMD_DEQ: begin
            if (!q_ok) begin
              status_nxt = lqt_pkg::ST_ERR;
              state_nxt  = S_DONE;
            end else begin
              n_re      = 1'b1;
              n_raddr   = sen_head;
              state_nxt = S_DQ1;
            end
          end
          default: begin
            if (tab_full) begin
              status_nxt = lqt_pkg::ST_ERR;
              state_nxt  = S_DONE;
            end else begin
              n_we = 1'b1; n_waddr = sen_head; n_wdata = sen_tail;
              p_we = 1'b1; p_waddr = sen_head; p_wdata = sen_head;
              state_nxt = S_AL2;
            end
          end
        endcase
      end
      S_ENQ1: begin
        last_nxt = p_link;
        n_we = 1'b1; n_waddr = pid_r; n_wdata = sen_tail;
        p_we = 1'b1; p_waddr = pid_r; p_wdata = p_link;
        state_nxt = S_ENQ2;
      end
      S_ENQ2: begin
        n_we = 1'b1; n_waddr = last_r;   n_wdata = pid_r;
        p_we = 1'b1; p_waddr = sen_tail; p_wdata = pid_r;
        pidout_nxt = pid_r;
        state_nxt  = S_DONE;
      end
      S_DQ1: begin
        if (is_proc(n_raw)) begin
          pid_nxt    = n_raw;
          pidout_nxt = n_raw;
          n_re       = 1'b1;
          n_raddr    = n_raw;
          p_re       = 1'b1;
          p_raddr    = n_raw;
          state_nxt  = S_UNL;
        end else begin
          status_nxt = lqt_pkg::ST_EMPTY;
          state_nxt  = S_DONE;
        end
      end
      S_UNL: begin
        // Splice the entry out: prev's next skips forward, next's prev skips back.
        n_we = 1'b1; n_waddr = p_link; n_wdata = n_link;
        p_we = 1'b1; p_waddr = n_link; p_wdata = p_link;
        state_nxt = (cmd_r == lqt_pkg::CMD_DEQ) ? S_DQ3 : S_DONE;
      end
      S_DQ3: begin
        n_we = 1'b1; n_waddr = pid_r; n_wdata = pid_r;
        p_we = 1'b1; p_waddr = pid_r; p_wdata = pid_r;
        state_nxt = S_DONE;
      end
      S_AL2: begin
        n_we = 1'b1; n_waddr = sen_tail; n_wdata = sen_tail;
        p_we = 1'b1; p_waddr = sen_tail; p_wdata = sen_head;
        qout_nxt  = LW'(qa_r);
        qa_nxt    = QA_W'(qa_r + 1'b1);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hold the result until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_data_nxt.status    = status_r;
          out_data_nxt.pid_out   = pidout_r;
          out_data_nxt.queue_out = qout_r;
          out_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      qa_r        <= '0;
      nvalid_r    <= '0;
      pvalid_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      qa_r        <= qa_nxt;
      if (n_we && is_proc(n_waddr)) begin
        nvalid_r[n_waddr[IDX_W-1:0]] <= 1'b1;
      end
      if (p_we && is_proc(p_waddr)) begin
        pvalid_r[p_waddr[IDX_W-1:0]] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    pid_r      <= pid_nxt;
    qid_r      <= qid_nxt;
    last_r     <= last_nxt;
    status_r   <= status_nxt;
    pidout_r   <= pidout_nxt;
    qout_r     <= qout_nxt;
    out_data_r <= out_data_nxt;
    if (n_re) begin
      n_rtag_r <= n_raddr;
      n_ovr_r  <= is_proc(n_raddr) && !nvalid_r[n_raddr[IDX_W-1:0]];
    end
    if (p_re) begin
      p_rtag_r <= p_raddr;
      p_ovr_r  <= is_proc(p_raddr) && !pvalid_r[p_raddr[IDX_W-1:0]];
    end
  end

  // Next-link memory.
  always_ff @(posedge clk) begin
    if (n_we) begin
      next_mem[n_waddr[ADDR_W-1:0]] <= n_wdata;
    end
    if (n_re) begin
      n_rdata_r <= next_mem[n_raddr[ADDR_W-1:0]];
    end
  end

  // Prev-link memory.
  always_ff @(posedge clk) begin
    if (p_we) begin
      prev_mem[p_waddr[ADDR_W-1:0]] <= p_wdata;
    end
    if (p_re) begin
      p_rdata_r <= prev_mem[p_raddr[ADDR_W-1:0]];
    end
  end

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_qa_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qa_r <= QA_W'(NUM_QUEUES))
    else $error("queue count beyond table size");

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_DEC)
    else $error("accepted word not decoded");

  a_nwr_range: assert property (@(posedge clk) disable iff (!rst_n)
    n_we |-> {1'b0, n_waddr} < (LW + 1)'(TAB_SIZE))
    else $error("next-link write outside table");

  a_pwr_range: assert property (@(posedge clk) disable iff (!rst_n)
    p_we |-> {1'b0, p_waddr} < (LW + 1)'(TAB_SIZE))
    else $error("prev-link write outside table");
`endif

endmodule
`default_nettype wire
